@@ rtl/olac_pkg.sv @@
// Package for the occupancy light and air conditioner controller.
// Holds the mode encodings, register indexes, shared structs and helpers.
// No dependencies.
`default_nettype none
package olac_pkg;

  localparam int unsigned TimerBits = 16;
  localparam int unsigned HoldBits  = 16;
  localparam int unsigned CmpBits   = (TimerBits > HoldBits) ? TimerBits : HoldBits;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  localparam int unsigned InDataBits  = 24;
  localparam int unsigned OutDataBits = 16;

  typedef logic [TimerBits-1:0] timer_t;
  typedef logic [HoldBits-1:0]  hold_t;

  typedef enum logic [1:0] {
    CAM_NONE    = 2'd0,
    CAM_LIKELY  = 2'd1,
    CAM_PRESENT = 2'd2
  } cam_state_e;

  typedef enum logic [1:0] {
    LT_OFF   = 2'd0,
    LT_CHECK = 2'd1,
    LT_ON    = 2'd2
  } light_state_e;

  typedef enum logic [1:0] {
    AC_CLOSED = 2'd0,
    AC_DOPEN  = 2'd1,
    AC_OPENED = 2'd2,
    AC_DCLOSE = 2'd3
  } ac_state_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_ON    = 2'd1,
    CMD_OFF   = 2'd2
  } ac_cmd_e;

  typedef enum logic [1:0] {
    FORCE_NORMAL  = 2'd0,
    FORCE_PRESENT = 2'd1,
    FORCE_ABSENT  = 2'd2
  } force_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_FRAME = 1'b1
  } op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_SCORE_HIGH   = 3'd0,
    REG_SCORE_LOW    = 3'd1,
    REG_LIKELY_HOLD  = 3'd2,
    REG_LIGHT_HOLD   = 3'd3,
    REG_DARK_LEVEL   = 3'd4,
    REG_AC_OPEN      = 3'd5,
    REG_AC_CLOSE     = 3'd6,
    REG_FORCE_MODE   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] score_high;
    logic [7:0] score_low;
    hold_t      likely_hold;
    hold_t      light_hold;
    logic [7:0] dark_level;
    hold_t      ac_open;
    hold_t      ac_close;
    logic [1:0] force_mode;
  } cfg_t;

  typedef struct packed {
    logic       op;
    logic [7:0] best_score;
    logic [7:0] brightness;
    logic       motion_seen;
  } item_t;

  typedef struct packed {
    logic       light_on;
    logic [1:0] aircon_command;
    logic [1:0] camera_mode;
    logic [1:0] light_mode;
    logic [1:0] aircon_mode;
  } res_t;

  function automatic logic hold_exceeded(input timer_t t, input hold_t h);
    logic [CmpBits-1:0] tw;
    logic [CmpBits-1:0] hw;
    tw = CmpBits'(t);
    hw = CmpBits'(h);
    return tw > hw;
  endfunction

  function automatic timer_t sat_inc(input timer_t t);
    return (t == '1) ? t : t + 1'b1;
  endfunction

endpackage
`default_nettype wire

@@ rtl/olac_cfg_regs.sv @@
// Configuration register bank of the occupancy controller.
// Depends on olac_pkg for the register indexes and the cfg_t struct.
`default_nettype none
module olac_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  input  wire logic [olac_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [olac_pkg::CfgDataBits-1:0] cfg_data_i,
  output olac_pkg::cfg_t                       cfg_o
);
  import olac_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SCORE_HIGH:  cfg_d.score_high  = cfg_data_i[7:0];
        REG_SCORE_LOW:   cfg_d.score_low   = cfg_data_i[7:0];
        REG_LIKELY_HOLD: cfg_d.likely_hold = cfg_data_i[HoldBits-1:0];
        REG_LIGHT_HOLD:  cfg_d.light_hold  = cfg_data_i[HoldBits-1:0];
        REG_DARK_LEVEL:  cfg_d.dark_level  = cfg_data_i[7:0];
        REG_AC_OPEN:     cfg_d.ac_open     = cfg_data_i[HoldBits-1:0];
        REG_AC_CLOSE:    cfg_d.ac_close    = cfg_data_i[HoldBits-1:0];
        REG_FORCE_MODE:  cfg_d.force_mode  = cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_high  <= 8'd70;
      cfg_q.score_low   <= 8'd55;
      cfg_q.likely_hold <= HoldBits'(30);
      cfg_q.light_hold  <= HoldBits'(50);
      cfg_q.dark_level  <= 8'd64;
      cfg_q.ac_open     <= HoldBits'(100);
      cfg_q.ac_close    <= HoldBits'(100);
      cfg_q.force_mode  <= FORCE_NORMAL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ rtl/olac_core.sv @@
// Camera, light and air conditioner mode machines with their timers.
// Evaluates one registered item per enabled cycle; depends on olac_pkg.
`default_nettype none
module olac_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire olac_pkg::cfg_t  cfg_i,
  input  wire olac_pkg::item_t item_i,
  input  wire logic           step_i,
  output olac_pkg::res_t      res_o
);
  import olac_pkg::*;

  cam_state_e   cam_q, cam_d;
  light_state_e light_q, light_d;
  ac_state_e    ac_q, ac_d;
  timer_t       likely_q, likely_d;
  timer_t       since_q, since_d;
  timer_t       ac_tmr_q, ac_tmr_d;
  ac_cmd_e      cmd;
  logic         present;
  logic         hi_hit;
  logic         lo_hit;

  always_comb begin
    cam_d    = cam_q;
    light_d  = light_q;
    ac_d     = ac_q;
    likely_d = likely_q;
    since_d  = since_q;
    ac_tmr_d = ac_tmr_q;
    cmd      = CMD_NONE;
    hi_hit   = item_i.best_score >= cfg_i.score_high;
    lo_hit   = item_i.best_score >= cfg_i.score_low;
    present  = 1'b0;

    if (item_i.op == OP_TICK) begin
      likely_d = sat_inc(likely_q);
      since_d  = sat_inc(since_q);
      ac_tmr_d = sat_inc(ac_tmr_q);
    end else begin
      case (cam_q)
        CAM_NONE: begin
          if (hi_hit) begin
            cam_d = CAM_PRESENT;
          end else if (lo_hit) begin
            likely_d = '0;
            cam_d    = CAM_LIKELY;
          end
        end
        CAM_LIKELY: begin
          if (hi_hit) begin
            cam_d = CAM_PRESENT;
          end else if (lo_hit) begin
            if (hold_exceeded(likely_q, cfg_i.likely_hold)) begin
              cam_d = CAM_PRESENT;
            end
          end else begin
            cam_d = CAM_NONE;
          end
        end
        default: begin
          if (!lo_hit) begin
            cam_d = CAM_NONE;
          end
        end
      endcase
      case (force_e'(cfg_i.force_mode))
        FORCE_PRESENT: cam_d = CAM_PRESENT;
        FORCE_ABSENT:  cam_d = CAM_NONE;
        default: begin
        end
      endcase

      present = (cam_d == CAM_PRESENT);
      if (present) begin
        since_d = '0;
      end

      case (light_q)
        LT_OFF: begin
          if (present) begin
            light_d = LT_ON;
          end else if (item_i.motion_seen && (item_i.brightness < cfg_i.dark_level)) begin
            light_d = LT_CHECK;
          end
        end
        LT_CHECK: begin
          if (present) begin
            light_d = LT_ON;
          end else if (!item_i.motion_seen) begin
            light_d = LT_OFF;
          end
        end
        default: begin
          if (hold_exceeded(since_d, cfg_i.light_hold) && !item_i.motion_seen) begin
            light_d = LT_OFF;
          end
        end
      endcase

      case (ac_q)
        AC_CLOSED: begin
          if (light_d == LT_ON) begin
            ac_tmr_d = '0;
            ac_d     = AC_DOPEN;
          end
        end
        AC_DOPEN: begin
          if (light_d != LT_ON) begin
            ac_d = AC_CLOSED;
          end else if (hold_exceeded(ac_tmr_q, cfg_i.ac_open)) begin
            ac_d = AC_OPENED;
            cmd  = CMD_ON;
          end
        end
        AC_OPENED: begin
          if (light_d != LT_ON) begin
            ac_tmr_d = '0;
            ac_d     = AC_DCLOSE;
          end
        end
        default: begin
          if (light_d == LT_ON) begin
            ac_d = AC_OPENED;
          end else if (hold_exceeded(ac_tmr_q, cfg_i.ac_close)) begin
            ac_d = AC_CLOSED;
            cmd  = CMD_OFF;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q    <= CAM_NONE;
      light_q  <= LT_OFF;
      ac_q     <= AC_CLOSED;
      likely_q <= '0;
      since_q  <= '1;
      ac_tmr_q <= '0;
    end else if (step_i) begin
      cam_q    <= cam_d;
      light_q  <= light_d;
      ac_q     <= ac_d;
      likely_q <= likely_d;
      since_q  <= since_d;
      ac_tmr_q <= ac_tmr_d;
    end
  end

  assign res_o.light_on       = (light_d != LT_OFF);
  assign res_o.aircon_command = cmd;
  assign res_o.camera_mode    = cam_d;
  assign res_o.light_mode     = light_d;
  assign res_o.aircon_mode    = ac_d;

endmodule
`default_nettype wire

@@ rtl/occupancy_light_aircon_controller_top.sv @@
// Top level of the occupancy light and air conditioner controller.
// Instantiates olac_cfg_regs and olac_core; depends on olac_pkg.
//
// The controller takes one request per clock cycle unless a frame request waits for
// the result register: a tick request advances the three saturating timers and gives
// no result, a frame request runs the camera, light and air conditioner machines and
// gives one result. The input and result registers lie around the single evaluation
// stage; the result register lets the next request enter while a result waits to be
// taken. Configuration writes are always accepted and take effect on the next cycle.
`default_nettype none
module occupancy_light_aircon_controller_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // best_score [7:0], brightness [15:8], motion_seen [16], zero [23:17]
  input  wire logic [olac_pkg::InDataBits-1:0]  s_axis_tdata,
  // op [0]
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // light_on [0], aircon_command [2:1], camera_mode [4:3], light_mode [6:5],
  // aircon_mode [8:7], zero [15:9]
  output logic [olac_pkg::OutDataBits-1:0]      m_axis_tdata,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [olac_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [olac_pkg::CfgDataBits-1:0] cfg_data_i
);
  import olac_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  logic  in_valid_q;
  res_t  res;
  res_t  res_q;
  logic  out_valid_q;
  logic  out_free;
  logic  step;
  logic  in_take;

  assign cfg_ready_o = 1'b1;

  olac_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && ((item_q.op == OP_TICK) || out_free);
  assign s_axis_tready = !in_valid_q || step;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.op          <= s_axis_tuser;
      item_q.best_score  <= s_axis_tdata[7:0];
      item_q.brightness  <= s_axis_tdata[15:8];
      item_q.motion_seen <= s_axis_tdata[16];
    end
  end

  olac_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item_q),
    .step_i (step),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && (item_q.op == OP_FRAME);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && (item_q.op == OP_FRAME)) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, res_q.aircon_mode, res_q.light_mode, res_q.camera_mode,
                          res_q.aircon_command, res_q.light_on};

endmodule
`default_nettype wire
